/* hdl/nr_transport_block_size_unit_macros.svh */
// assertion macros shared by the transport block size unit
`ifndef NR_TRANSPORT_BLOCK_SIZE_UNIT_MACROS_SVH
`define NR_TRANSPORT_BLOCK_SIZE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NRTBS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nrtbs: same-cycle check failed");
`define NRTBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nrtbs: next-cycle check failed");
`else
`define NRTBS_ASSERT_IMPLY(lbl, ante, cons)
`define NRTBS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/nrtbs_pkg.sv */
// types, constants and tables of the transport block size unit
package nrtbs_pkg;

  localparam int TBS_TABLE_ENTRIES = 93;
  localparam int MAX_PRB           = 275;

  // field widths
  localparam int MCS_W   = 5;
  localparam int PRB_W   = 9;
  localparam int QM_W    = 4;
  localparam int R5_W    = 11;
  localparam int RATE_W  = 14;
  localparam int TBS_W   = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // internal widths
  localparam int RE_W    = 8;
  localparam int NRE_W   = 16;
  localparam int P_W     = 27;
  localparam int QMV_W   = 7;
  localparam int PROD_W  = 34;
  localparam int NINFO_W = 22;
  localparam int LOG_W   = 5;
  localparam int NP_W    = 23;
  localparam int Y_W     = 24;
  localparam int C_W     = 12;
  localparam int D_W     = 15;
  localparam int Q_W     = 11;
  localparam int DS_W    = D_W + Q_W;
  localparam int SMALL_W = 12;
  localparam int IDX_W   = 7;

  // numeric constants of the size rules
  localparam int RE_CAP      = 156;
  localparam int RE_PER_SYM  = 12;
  localparam int INFO_SHIFT  = 11;
  localparam int SMALL_MAX   = 3824;
  localparam int LARGE_MIN   = 3840;
  localparam int SEG_LOW     = 3816;
  localparam int SEG_HIGH    = 8424;
  localparam int RATE_LOW_R5 = 2560 / 5;
  localparam int RATE_DIV    = 5;
  localparam int TBS_MIN     = 24;
  localparam int TBS_MAX     = 2097151;
  localparam int QUANT_LOG_MIN = 9;

  // reciprocals for the two segment sizes
  localparam int RECIP_S  = 38;
  localparam int RECIP_W  = 27;
  localparam int RPROD_W  = Y_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_SEG_LOW =
    RECIP_W'(((64'd1 << RECIP_S) + 64'(SEG_LOW) - 64'd1) / 64'(SEG_LOW));
  localparam logic [RECIP_W-1:0] RECIP_SEG_HIGH =
    RECIP_W'(((64'd1 << RECIP_S) + 64'(SEG_HIGH) - 64'd1) / 64'(SEG_HIGH));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MCS_TABLE    = 3'd0,
    CFG_SYMBOLS      = 3'd1,
    CFG_DMRS_RE      = 3'd2,
    CFG_OVERHEAD_RE  = 3'd3,
    CFG_SCALING      = 3'd4,
    CFG_LAYERS       = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] mcs_table;
    logic [3:0] symbols_per_slot;
    logic [6:0] dmrs_re_per_prb;
    logic [4:0] overhead_re_per_prb;
    logic [1:0] scaling_shift;
    logic [2:0] layer_count;
  } cfg_t;

  typedef struct packed {
    logic [QM_W-1:0] qm;
    logic [R5_W-1:0] r5;
  } mcs_t;

  typedef struct packed {
    logic [NINFO_W-1:0] ninfo;
    mcs_t               mcs;
  } ninfo_t;

  typedef struct packed {
    logic               is_small;
    logic [SMALL_W-1:0] tbs_small;
    logic [D_W-1:0]     d;
    logic [Y_W-1:0]     x;
    mcs_t               mcs;
  } quant_t;

  typedef struct packed {
    logic [TBS_W-1:0]  tbs_bits;
    logic [QM_W-1:0]   mod_order;
    logic [RATE_W-1:0] rate_x10240;
    logic              reserved_mcs;
  } result_t;

  localparam logic [SMALL_W-1:0] TBS_SMALL [TBS_TABLE_ENTRIES] = '{
    12'd24, 12'd32, 12'd40, 12'd48, 12'd56, 12'd64, 12'd72, 12'd80, 12'd88, 12'd96,
    12'd104, 12'd112, 12'd120, 12'd128, 12'd136, 12'd144, 12'd152, 12'd160, 12'd168,
    12'd176, 12'd184, 12'd192, 12'd208, 12'd224, 12'd240, 12'd256, 12'd272, 12'd288,
    12'd304, 12'd320, 12'd336, 12'd352, 12'd368, 12'd384, 12'd408, 12'd432, 12'd456,
    12'd480, 12'd504, 12'd528, 12'd552, 12'd576, 12'd608, 12'd640, 12'd672, 12'd704,
    12'd736, 12'd768, 12'd808, 12'd848, 12'd888, 12'd928, 12'd984, 12'd1032, 12'd1064,
    12'd1128, 12'd1160, 12'd1192, 12'd1224, 12'd1256, 12'd1288, 12'd1320, 12'd1352,
    12'd1416, 12'd1480, 12'd1544, 12'd1608, 12'd1672, 12'd1736, 12'd1800, 12'd1864,
    12'd1928, 12'd2024, 12'd2088, 12'd2152, 12'd2216, 12'd2280, 12'd2408, 12'd2472,
    12'd2536, 12'd2600, 12'd2664, 12'd2728, 12'd2792, 12'd2856, 12'd2976, 12'd3104,
    12'd3240, 12'd3368, 12'd3496, 12'd3624, 12'd3752, 12'd3824
  };

  localparam logic [QM_W-1:0] QM_TAB [3][32] = '{
    '{4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4, 4'd4,
      4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
      4'd6, 4'd2, 4'd4, 4'd6},
    '{4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6,
      4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
      4'd2, 4'd4, 4'd6, 4'd8},
    '{4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
      4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
      4'd6, 4'd2, 4'd4, 4'd6}
  };

  // code rate times 10240, divided by five (every entry is a multiple of five)
  localparam logic [R5_W-1:0] R5_TAB [3][32] = '{
    '{11'd240, 11'd314, 11'd386, 11'd502, 11'd616, 11'd758, 11'd898, 11'd1052, 11'd1204,
      11'd1358, 11'd680, 11'd756, 11'd868, 11'd980, 11'd1106, 11'd1232, 11'd1316, 11'd876,
      11'd932, 11'd1034, 11'd1134, 11'd1232, 11'd1332, 11'd1438, 11'd1544, 11'd1644,
      11'd1746, 11'd1820, 11'd1896, 11'd0, 11'd0, 11'd0},
    '{11'd240, 11'd386, 11'd616, 11'd898, 11'd1204, 11'd756, 11'd868, 11'd980, 11'd1106,
      11'd1232, 11'd1316, 11'd932, 11'd1034, 11'd1134, 11'd1232, 11'd1332, 11'd1438,
      11'd1544, 11'd1644, 11'd1746, 11'd1365, 11'd1422, 11'd1508, 11'd1594, 11'd1682,
      11'd1770, 11'd1833, 11'd1896, 11'd0, 11'd0, 11'd0, 11'd0},
    '{11'd60, 11'd80, 11'd100, 11'd128, 11'd156, 11'd198, 11'd240, 11'd314, 11'd386,
      11'd502, 11'd616, 11'd758, 11'd898, 11'd1052, 11'd1204, 11'd680, 11'd756, 11'd868,
      11'd980, 11'd1106, 11'd1232, 11'd876, 11'd932, 11'd1034, 11'd1134, 11'd1232,
      11'd1332, 11'd1438, 11'd1544, 11'd0, 11'd0, 11'd0}
  };

  // position of the highest set bit, zero for zero
  function automatic logic [LOG_W-1:0] floor_log2(input logic [NINFO_W-1:0] v);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 0; i < NINFO_W; i++) begin
      if (v[i]) r = LOG_W'(i);
    end
    return r;
  endfunction

endpackage

/* hdl/nrtbs_in_if.sv */
// input channel: mcs index and prb count
interface nrtbs_in_if;
  logic                        valid;
  logic                        ready;
  logic [nrtbs_pkg::MCS_W-1:0] mcs_index;
  logic [nrtbs_pkg::PRB_W-1:0] prb_count;

  modport source (output valid, output mcs_index, output prb_count, input ready);
  modport sink (input valid, input mcs_index, input prb_count, output ready);
endinterface

/* hdl/nrtbs_out_if.sv */
// output channel: transport block size result
interface nrtbs_out_if;
  logic                         valid;
  logic                         ready;
  logic [nrtbs_pkg::TBS_W-1:0]  tbs_bits;
  logic [nrtbs_pkg::QM_W-1:0]   mod_order;
  logic [nrtbs_pkg::RATE_W-1:0] rate_x10240;
  logic                         reserved_mcs;

  modport source (output valid, output tbs_bits, output mod_order, output rate_x10240,
                  output reserved_mcs, input ready);
  modport sink (input valid, input tbs_bits, input mod_order, input rate_x10240,
                input reserved_mcs, output ready);
endinterface

/* hdl/nr_transport_block_size_unit.sv */
// an accepted item passes through the ninfo, quantization and division pipelines to result_out
// throughput: one item per cycle while result_out is ready, set by the 11-stage quotient pipeline
// every stage holds its item under backpressure and takes a new one when free
// reset clears all stage valid bits and loads the configuration defaults
// no table or memory needs clearing after reset
`include "nr_transport_block_size_unit_macros.svh"
module nr_transport_block_size_unit #(
  parameter int MAX_PRB = nrtbs_pkg::MAX_PRB
) (
  input  logic                             clk,
  input  logic                             rst,
  nrtbs_in_if.sink                         item_in,
  nrtbs_out_if.source                      result_out,
  input  logic                             cfg_write,
  input  logic [nrtbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nrtbs_pkg::CFG_DATA_W-1:0] cfg_data
);

  nrtbs_pkg::cfg_t    cfg;
  logic               ni_valid, ni_ready, qt_valid, qt_ready;
  nrtbs_pkg::ninfo_t  ni_data;
  nrtbs_pkg::quant_t  qt_data;
  nrtbs_pkg::result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mcs_table           <= 2'd1;
      cfg.symbols_per_slot    <= 4'd13;
      cfg.dmrs_re_per_prb     <= 7'd12;
      cfg.overhead_re_per_prb <= 5'd0;
      cfg.scaling_shift       <= 2'd0;
      cfg.layer_count         <= 3'd1;
    end else if (cfg_write) begin
      case (nrtbs_pkg::cfg_idx_t'(cfg_index))
        nrtbs_pkg::CFG_MCS_TABLE:   cfg.mcs_table           <= cfg_data[1:0];
        nrtbs_pkg::CFG_SYMBOLS:     cfg.symbols_per_slot    <= cfg_data[3:0];
        nrtbs_pkg::CFG_DMRS_RE:     cfg.dmrs_re_per_prb     <= cfg_data[6:0];
        nrtbs_pkg::CFG_OVERHEAD_RE: cfg.overhead_re_per_prb <= cfg_data[4:0];
        nrtbs_pkg::CFG_SCALING:     cfg.scaling_shift       <= cfg_data[1:0];
        nrtbs_pkg::CFG_LAYERS:      cfg.layer_count         <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // ninfo front end
  nrtbs_ninfo #(.MAX_PRB(MAX_PRB)) u_ninfo (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .mcs_index (item_in.mcs_index),
    .prb_count (item_in.prb_count),
    .out_valid (ni_valid),
    .out_ready (ni_ready),
    .out_data  (ni_data)
  );

  // quantization and segment count
  nrtbs_quant u_quant (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ni_valid),
    .in_ready  (ni_ready),
    .in_data   (ni_data),
    .out_valid (qt_valid),
    .out_ready (qt_ready),
    .out_data  (qt_data)
  );

  // ceiling division and output register
  nrtbs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (qt_valid),
    .in_ready  (qt_ready),
    .in_data   (qt_data),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (res)
  );

  assign result_out.tbs_bits     = res.tbs_bits;
  assign result_out.mod_order    = res.mod_order;
  assign result_out.rate_x10240  = res.rate_x10240;
  assign result_out.reserved_mcs = res.reserved_mcs;

  // a reserved entry always maps to the smallest size
  `NRTBS_ASSERT_IMPLY(a_reserved_min_tbs, result_out.valid && result_out.reserved_mcs, result_out.tbs_bits == nrtbs_pkg::TBS_W'(nrtbs_pkg::TBS_MIN))

endmodule

/* hdl/nrtbs_ninfo.sv */
// four-stage pipeline from mcs index and prb count to ninfo
module nrtbs_ninfo #(
  parameter int MAX_PRB = nrtbs_pkg::MAX_PRB
) (
  input  logic                        clk,
  input  logic                        rst,
  input  nrtbs_pkg::cfg_t             cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [nrtbs_pkg::MCS_W-1:0] mcs_index,
  input  logic [nrtbs_pkg::PRB_W-1:0] prb_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output nrtbs_pkg::ninfo_t           out_data
);

  localparam int NST = 4;

  logic [NST-1:0] v;
  logic [NST:0]   adv;

  // stage 1 logic
  logic [nrtbs_pkg::PRB_W-1:0] prb_sat;
  nrtbs_pkg::mcs_t             mcs_l;
  logic [nrtbs_pkg::RE_W-1:0]  gross, removed, re_prb;
  logic [nrtbs_pkg::QMV_W-1:0] qmv;

  // stage registers
  logic [nrtbs_pkg::PRB_W-1:0]   prb1;
  logic [nrtbs_pkg::RE_W-1:0]    re1;
  logic [nrtbs_pkg::QMV_W-1:0]   qmv1, qmv2, qmv3;
  nrtbs_pkg::mcs_t               mcs1, mcs2, mcs3;
  logic [nrtbs_pkg::NRE_W-1:0]   nre2;
  logic [nrtbs_pkg::P_W-1:0]     p3;
  logic [nrtbs_pkg::PROD_W-1:0]  prod;
  nrtbs_pkg::ninfo_t             s4;

  // per-stage advance, a stage moves when empty or when its successor moves
  always_comb begin
    adv[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  // table lookup, prb clamp and re count per prb
  always_comb begin
    prb_sat = (prb_count > nrtbs_pkg::PRB_W'(MAX_PRB)) ? nrtbs_pkg::PRB_W'(MAX_PRB)
                                                       : prb_count;
    mcs_l = '0;
    if (cfg.mcs_table < 2'd3) begin
      mcs_l.qm = nrtbs_pkg::QM_TAB[cfg.mcs_table][mcs_index];
      mcs_l.r5 = nrtbs_pkg::R5_TAB[cfg.mcs_table][mcs_index];
    end
    gross   = nrtbs_pkg::RE_W'(cfg.symbols_per_slot) * nrtbs_pkg::RE_W'(nrtbs_pkg::RE_PER_SYM);
    removed = nrtbs_pkg::RE_W'(cfg.dmrs_re_per_prb) + nrtbs_pkg::RE_W'(cfg.overhead_re_per_prb);
    re_prb  = (gross > removed) ? gross - removed : '0;
    if (re_prb > nrtbs_pkg::RE_W'(nrtbs_pkg::RE_CAP)) re_prb = nrtbs_pkg::RE_W'(nrtbs_pkg::RE_CAP);
    qmv = nrtbs_pkg::QMV_W'(mcs_l.qm) * nrtbs_pkg::QMV_W'(cfg.layer_count);
  end

  // last stage product, scaled down
  assign prod = nrtbs_pkg::PROD_W'(p3) * nrtbs_pkg::PROD_W'(qmv3);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prb1 <= prb_sat;
      re1  <= re_prb;
      qmv1 <= qmv;
      mcs1 <= mcs_l;
    end
    if (adv[1]) begin
      nre2 <= nrtbs_pkg::NRE_W'(nrtbs_pkg::NRE_W'(re1) * nrtbs_pkg::NRE_W'(prb1));
      qmv2 <= qmv1;
      mcs2 <= mcs1;
    end
    if (adv[2]) begin
      p3   <= nrtbs_pkg::P_W'(nrtbs_pkg::P_W'(nre2) * nrtbs_pkg::P_W'(mcs2.r5));
      qmv3 <= qmv2;
      mcs3 <= mcs2;
    end
    if (adv[3]) begin
      s4.ninfo <= nrtbs_pkg::NINFO_W'((prod >> nrtbs_pkg::INFO_SHIFT) >> cfg.scaling_shift);
      s4.mcs   <= mcs3;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[NST-1];
  assign out_data  = s4;

endmodule

/* hdl/nrtbs_quant.sv */
// three-stage quantization: small table match and large segment count
`include "nr_transport_block_size_unit_macros.svh"
module nrtbs_quant (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  nrtbs_pkg::ninfo_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output nrtbs_pkg::quant_t out_data
);

  localparam int NST = 3;

  logic [NST-1:0] v;
  logic [NST:0]   adv;

  // stage 5 logic
  logic [nrtbs_pkg::NINFO_W-1:0] ni, m, half;
  logic [nrtbs_pkg::LOG_W-1:0]   fl_s, fl_l, n_l;
  logic [2:0]                    n_s;
  logic [nrtbs_pkg::NP_W-1:0]    np_s, np_l, sum_l;
  logic                          is_small;

  // stage 6 logic
  logic [nrtbs_pkg::Y_W-1:0]               y, y_up;
  logic [nrtbs_pkg::TBS_TABLE_ENTRIES-1:0] lt;
  logic                                    c_one;
  logic [nrtbs_pkg::RECIP_W-1:0]           recip;

  // stage 7 logic
  logic [nrtbs_pkg::C_W-1:0]     c;
  logic [nrtbs_pkg::IDX_W-1:0]   idx;
  nrtbs_pkg::quant_t             q_next;

  // stage registers
  logic [nrtbs_pkg::NP_W-1:0]              np5;
  logic                                    small5, rlow5, small6, c_one6;
  nrtbs_pkg::mcs_t                         mcs5, mcs6;
  logic [nrtbs_pkg::Y_W-1:0]               y6;
  logic [nrtbs_pkg::RPROD_W-1:0]           rprod6;
  logic [nrtbs_pkg::TBS_TABLE_ENTRIES-1:0] lt6;
  nrtbs_pkg::quant_t                       s7;

  always_comb begin
    adv[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  // quantize ninfo on both paths, pick by size
  always_comb begin
    ni       = in_data.ninfo;
    is_small = ni <= nrtbs_pkg::NINFO_W'(nrtbs_pkg::SMALL_MAX);
    fl_s     = nrtbs_pkg::floor_log2(ni);
    n_s = (ni != '0 && fl_s >= nrtbs_pkg::LOG_W'(nrtbs_pkg::QUANT_LOG_MIN))
          ? 3'(fl_s - nrtbs_pkg::LOG_W'(6)) : 3'd3;
    np_s = nrtbs_pkg::NP_W'((ni >> n_s) << n_s);
    if (np_s < nrtbs_pkg::NP_W'(nrtbs_pkg::TBS_MIN)) np_s = nrtbs_pkg::NP_W'(nrtbs_pkg::TBS_MIN);
    m     = ni - nrtbs_pkg::NINFO_W'(nrtbs_pkg::TBS_MIN);
    fl_l  = nrtbs_pkg::floor_log2(m);
    n_l   = fl_l - nrtbs_pkg::LOG_W'(5);
    half  = nrtbs_pkg::NINFO_W'(1) << (n_l - nrtbs_pkg::LOG_W'(1));
    sum_l = nrtbs_pkg::NP_W'(m) + nrtbs_pkg::NP_W'(half);
    np_l  = (sum_l >> n_l) << n_l;
    if (np_l < nrtbs_pkg::NP_W'(nrtbs_pkg::LARGE_MIN)) np_l = nrtbs_pkg::NP_W'(nrtbs_pkg::LARGE_MIN);
  end

  // table compares and segment count estimate
  always_comb begin
    y = nrtbs_pkg::Y_W'(np5) + nrtbs_pkg::Y_W'(nrtbs_pkg::TBS_MIN);
    // ceiling of the segment count: add segment size less one before the reciprocal
    y_up = nrtbs_pkg::Y_W'(np5) +
           (rlow5 ? nrtbs_pkg::Y_W'(nrtbs_pkg::SEG_LOW - 1 + nrtbs_pkg::TBS_MIN)
                  : nrtbs_pkg::Y_W'(nrtbs_pkg::SEG_HIGH - 1 + nrtbs_pkg::TBS_MIN));
    for (int i = 0; i < nrtbs_pkg::TBS_TABLE_ENTRIES; i++) begin
      lt[i] = nrtbs_pkg::NP_W'(nrtbs_pkg::TBS_SMALL[i]) < np5;
    end
    c_one = !rlow5 && (np5 <= nrtbs_pkg::NP_W'(nrtbs_pkg::SEG_HIGH));
    recip = rlow5 ? nrtbs_pkg::RECIP_SEG_LOW : nrtbs_pkg::RECIP_SEG_HIGH;
  end

  // table index, divisor and ceiling dividend
  always_comb begin
    c   = c_one6 ? nrtbs_pkg::C_W'(1) : nrtbs_pkg::C_W'(rprod6 >> nrtbs_pkg::RECIP_S);
    idx = nrtbs_pkg::IDX_W'($countones(lt6));
    if (idx > nrtbs_pkg::IDX_W'(nrtbs_pkg::TBS_TABLE_ENTRIES - 1)) begin
      idx = nrtbs_pkg::IDX_W'(nrtbs_pkg::TBS_TABLE_ENTRIES - 1);
    end
    q_next.is_small  = small6;
    q_next.tbs_small = nrtbs_pkg::TBS_SMALL[idx];
    q_next.mcs       = mcs6;
    if (small6) begin
      q_next.d = nrtbs_pkg::D_W'(8);
      q_next.x = '0;
    end else begin
      q_next.d = nrtbs_pkg::D_W'(c) << 3;
      q_next.x = y6 + nrtbs_pkg::Y_W'(q_next.d) - nrtbs_pkg::Y_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      np5    <= is_small ? np_s : np_l;
      small5 <= is_small;
      rlow5  <= in_data.mcs.r5 <= nrtbs_pkg::R5_W'(nrtbs_pkg::RATE_LOW_R5);
      mcs5   <= in_data.mcs;
    end
    if (adv[1]) begin
      y6     <= y;
      rprod6 <= nrtbs_pkg::RPROD_W'(y_up) * nrtbs_pkg::RPROD_W'(recip);
      c_one6 <= c_one;
      lt6    <= lt;
      small6 <= small5;
      mcs6   <= mcs5;
    end
    if (adv[2]) begin
      s7 <= q_next;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[NST-1];
  assign out_data  = s7;

  // large items always leave with a nonzero divisor
  `NRTBS_ASSERT_IMPLY(a_divisor_nonzero, v[NST-1] && !s7.is_small, s7.d != '0)
  // a held result stays valid while downstream stalls
  `NRTBS_ASSERT_NEXT(a_stall_keeps_item, !rst && v[NST-1] && !out_ready, v[NST-1])

endmodule

/* hdl/nrtbs_div.sv */
// pipelined ceiling division, one quotient bit a stage, then tbs rounding
`include "nr_transport_block_size_unit_macros.svh"
module nrtbs_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nrtbs_pkg::quant_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nrtbs_pkg::result_t out_data
);

  localparam int QW  = nrtbs_pkg::Q_W;
  localparam int NST = QW + 1;

  typedef struct packed {
    logic                          is_small;
    logic [nrtbs_pkg::SMALL_W-1:0] tbs_small;
    logic [nrtbs_pkg::D_W-1:0]     d;
    logic [nrtbs_pkg::Y_W-1:0]     rem;
    logic [QW-1:0]                 q;
    nrtbs_pkg::mcs_t               mcs;
  } dstage_t;

  logic [NST-1:0] v;
  logic [NST:0]   adv;
  dstage_t        first;
  dstage_t        st [QW];

  logic [nrtbs_pkg::DS_W-1:0] full, tbs_l;
  nrtbs_pkg::result_t         res_next, res;

  always_comb begin
    adv[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  // dividend enters as the running remainder
  always_comb begin
    first.is_small  = in_data.is_small;
    first.tbs_small = in_data.tbs_small;
    first.d         = in_data.d;
    first.rem       = in_data.x;
    first.q         = '0;
    first.mcs       = in_data.mcs;
  end

  // restoring division, msb of the quotient first
  for (genvar i = 0; i < QW; i++) begin : g_step
    dstage_t                    prev, nxt;
    logic [nrtbs_pkg::DS_W-1:0] dsh;

    if (i == 0) begin : g_first
      assign prev = first;
    end else begin : g_rest
      assign prev = st[i-1];
    end

    always_comb begin
      nxt = prev;
      dsh = nrtbs_pkg::DS_W'(prev.d) << (QW - 1 - i);
      if (nrtbs_pkg::DS_W'(prev.rem) >= dsh) begin
        nxt.rem          = prev.rem - nrtbs_pkg::Y_W'(dsh);
        nxt.q[QW - 1 - i] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i]) st[i] <= nxt;
    end
  end

  // rounded size, saturated to the field
  always_comb begin
    full  = nrtbs_pkg::DS_W'(st[QW-1].d) * nrtbs_pkg::DS_W'(st[QW-1].q);
    tbs_l = full - nrtbs_pkg::DS_W'(nrtbs_pkg::TBS_MIN);
    if (tbs_l > nrtbs_pkg::DS_W'(nrtbs_pkg::TBS_MAX)) begin
      tbs_l = nrtbs_pkg::DS_W'(nrtbs_pkg::TBS_MAX);
    end
    res_next.tbs_bits = st[QW-1].is_small ? nrtbs_pkg::TBS_W'(st[QW-1].tbs_small)
                                          : nrtbs_pkg::TBS_W'(tbs_l);
    res_next.mod_order    = st[QW-1].mcs.qm;
    res_next.rate_x10240  = nrtbs_pkg::RATE_W'(st[QW-1].mcs.r5) *
                            nrtbs_pkg::RATE_W'(nrtbs_pkg::RATE_DIV);
    res_next.reserved_mcs = st[QW-1].mcs.r5 == '0;
  end

  always_ff @(posedge clk) begin
    if (adv[QW]) res <= res_next;
  end

  assign in_ready  = adv[0];
  assign out_valid = v[NST-1];
  assign out_data  = res;

  // the remainder ends below the divisor
  `NRTBS_ASSERT_IMPLY(a_rem_below_divisor, v[QW-1], st[QW-1].rem < nrtbs_pkg::Y_W'(st[QW-1].d))
  // a large item needs at least one code block of data
  `NRTBS_ASSERT_IMPLY(a_large_quotient, v[QW-1] && !st[QW-1].is_small, st[QW-1].q != '0)

endmodule
